### hw/rtl/dqt_pkg.sv
// shared types, codes and helpers of the dns query id translation table
package dqt_pkg;

   localparam int DQT_DEPTH = 512;
   localparam int SLOT_W = 9;
   localparam logic [15:0] LFSR_SEED = 16'hACE1;
   localparam logic [15:0] LFSR_MASK = 16'hB400;
   localparam logic [15:0] ID_WRAP = 16'hFFFF;
   localparam logic [15:0] DRAW_LIMIT = 16'hFFFF;
   localparam logic [7:0] TIMEOUT_RESET = 8'd3;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_ANSWER = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   typedef enum logic [2:0] {
      STATUS_STORED = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_FULL = 3'd2,
      STATUS_MATCHED = 3'd3,
      STATUS_UNKNOWN = 3'd4,
      STATUS_TICK = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_HOME,
      FSM_READ,
      FSM_EVAL
   } fsm_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] tag_id;
      logic [15:0] real_id;
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] stamp;
   } entry_type;

   // galois step
   function automatic logic [15:0] lfsr_step(input logic [15:0] l);
      logic [15:0] n;
      n = {1'b0, l[15:1]};
      if (l[0]) begin
         n = n ^ LFSR_MASK;
      end
      return n;
   endfunction

endpackage

### hw/rtl/dqt_ram.sv
// generic single write port ram with registered read
module dqt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/dqt_home_mod.sv
// id mod depth unit: reciprocal multiply, then multiply back and subtract
module dqt_home_mod #(
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [15:0]              id_value,
   output logic                     done,
   output logic [$clog2(DEPTH)-1:0] home
);
   localparam int IW = $clog2(DEPTH);
   // ceil(2^32 / depth) gives the exact quotient for every 16-bit id
   localparam longint RECIP = ((64'd1 << 32) + DEPTH - 1) / DEPTH;
   localparam logic [31:0] RECIP_W = RECIP[31:0];
   localparam logic [16:0] DEPTH_W = DEPTH[16:0];

   logic [15:0]   id_ff, id_in;
   logic [15:0]   quot_ff, quot_in;
   logic [IW-1:0] rem_ff, rem_in;
   logic          mul_ff, mul_in;
   logic          done_ff, done_in;
   logic [47:0]   prod;
   logic [32:0]   back;
   logic [32:0]   diff;

   always_comb begin
      prod = 48'(id_value) * 48'(RECIP_W);
      back = 33'(quot_ff) * 33'(DEPTH_W);
      diff = 33'(id_ff) - back;
      id_in = id_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      mul_in = start;
      done_in = mul_ff;
      // quotient from the reciprocal, registered with the id
      if (start) begin
         id_in = id_value;
         quot_in = prod[47:32];
      end
      // then the remainder from the registered quotient
      if (mul_ff) begin
         rem_in = diff[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff <= mul_in;
         done_ff <= done_in;
      end
      id_ff <= id_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;
endmodule

### hw/rtl/dns_query_id_translation_table.sv
// top level: pending dns query id table, hashed by id mod depth, linear probing
// a tick answers at once; an add or answer finds its home slot, then reads and evaluates slot by slot
// an add that redraws its id goes back to the home step and probes from the new home slot
// throughput: one transaction at a time, busy high until the result strobe of an add or answer
// the probe loop over the single read port of the table ram sets the rate
// reset: synchronous; then a clearing pass over every slot with busy high
module dns_query_id_translation_table
   import dqt_pkg::*;
#(
   parameter int TABLE_DEPTH = DQT_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_mode,
   input  logic [15:0]  req_query_id,
   input  logic [31:0]  req_client_ip,
   input  logic [15:0]  req_client_port,
   output logic         rsp_valid,
   output logic [2:0]   rsp_status,
   output logic [8:0]   rsp_slot,
   output logic [15:0]  rsp_out_id,
   output logic [31:0]  rsp_out_ip,
   output logic [15:0]  rsp_out_port,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data
);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] LAST_COUNT = CW'(TABLE_DEPTH - 1);

   fsm_type state_ff, state_in;

   // transaction being worked on
   logic [1:0]    mode_ff, mode_in;
   logic [15:0]   id_ff, id_in;
   logic [15:0]   real_ff, real_in;
   logic [31:0]   ip_ff, ip_in;
   logic [15:0]   port_ff, port_in;
   logic [15:0]   draws_ff, draws_in;
   logic [IW-1:0] probe_ff, probe_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] clr_ff, clr_in;

   // block state
   logic [31:0]   now_ff, now_in;
   logic [15:0]   lfsr_ff, lfsr_in;
   logic [7:0]    timeout_ff, timeout_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    status_ff, status_in;
   logic [8:0]    slot_ff, slot_in;
   logic [15:0]   out_id_ff, out_id_in;
   logic [31:0]   out_ip_ff, out_ip_in;
   logic [15:0]   out_port_ff, out_port_in;

   logic          accept;
   logic          home_start;
   logic [15:0]   home_id;
   logic          home_done;
   logic [IW-1:0] home_slot;
   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   entry_type     ram_wdata;
   entry_type     rd_entry;
   logic [15:0]   step1;
   logic [15:0]   drawn;
   logic          hit_id;
   logic          same_client;
   logic          stale;
   logic          last_probe;

   assign accept = start && (state_ff == FSM_IDLE);
   assign busy = (state_ff != FSM_IDLE);
   assign csr_ready = 1'b1;

   // id draw: a step landing on 0xffff (which is 0 mod 0xffff) steps once more
   assign step1 = lfsr_step(lfsr_ff);
   assign drawn = (step1 == ID_WRAP) ? lfsr_step(step1) : step1;

   assign hit_id = rd_entry.valid && (rd_entry.tag_id == id_ff);
   assign same_client = (rd_entry.ip == ip_ff) && (rd_entry.port == port_ff);
   assign stale = ((now_ff - rd_entry.stamp) >= {24'd0, timeout_ff});
   assign last_probe = (count_ff == LAST_COUNT);

   dqt_home_mod #(.DEPTH(TABLE_DEPTH)) u_home (
      .clock    (clock),
      .reset    (reset),
      .start    (home_start),
      .id_value (home_id),
      .done     (home_done),
      .home     (home_slot)
   );

   dqt_ram #(.WIDTH($bits(entry_type)), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (probe_ff),
      .rd_data (rd_entry)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_CLEAR: begin
            if (clr_ff == LAST_SLOT) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (accept && (req_mode == MODE_ADD || req_mode == MODE_ANSWER)) begin
               state_in = FSM_HOME;
            end
         end
         FSM_HOME: begin
            if (home_done) begin
               state_in = FSM_READ;
            end
         end
         FSM_READ: state_in = FSM_EVAL;
         FSM_EVAL: begin
            if (mode_ff == MODE_ANSWER) begin
               state_in = (hit_id || last_probe) ? FSM_IDLE : FSM_READ;
            end else if (!rd_entry.valid) begin
               state_in = FSM_IDLE;
            end else if (rd_entry.tag_id == id_ff) begin
               // redraw restarts probing from the new home slot
               state_in = (same_client || draws_ff >= DRAW_LIMIT) ? FSM_IDLE : FSM_HOME;
            end else begin
               state_in = (stale || last_probe) ? FSM_IDLE : FSM_READ;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in = mode_ff;
      id_in = id_ff;
      real_in = real_ff;
      ip_in = ip_ff;
      port_in = port_ff;
      draws_in = draws_ff;
      probe_in = probe_ff;
      count_in = count_ff;
      clr_in = clr_ff;
      now_in = now_ff;
      lfsr_in = lfsr_ff;
      timeout_in = csr_valid ? csr_data : timeout_ff;
      rsp_valid_in = 1'b0;
      status_in = status_ff;
      slot_in = slot_ff;
      out_id_in = out_id_ff;
      out_ip_in = out_ip_ff;
      out_port_in = out_port_ff;
      home_start = 1'b0;
      home_id = req_query_id;
      ram_we = 1'b0;
      ram_waddr = probe_ff;
      ram_wdata = '0;
      case (state_ff)
         FSM_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         FSM_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               id_in = req_query_id;
               real_in = req_query_id;
               ip_in = req_client_ip;
               port_in = req_client_port;
               draws_in = '0;
               out_ip_in = '0;
               out_port_in = '0;
               if (req_mode == MODE_ADD || req_mode == MODE_ANSWER) begin
                  home_start = 1'b1;
               end else begin
                  // tick and the unused mode answer at once
                  if (req_mode == MODE_TICK) begin
                     now_in = now_ff + 32'd1;
                  end
                  rsp_valid_in = 1'b1;
                  status_in = STATUS_TICK;
                  slot_in = '0;
                  out_id_in = '0;
               end
            end
         end
         FSM_HOME: begin
            if (home_done) begin
               probe_in = home_slot;
               count_in = '0;
            end
         end
         FSM_READ: begin
         end
         FSM_EVAL: begin
            if (mode_ff == MODE_ANSWER) begin
               if (hit_id) begin
                  ram_we = 1'b1;
                  ram_wdata = rd_entry;
                  ram_wdata.valid = 1'b0;
                  rsp_valid_in = 1'b1;
                  status_in = STATUS_MATCHED;
                  slot_in = 9'(probe_ff);
                  out_id_in = rd_entry.real_id;
                  out_ip_in = rd_entry.ip;
                  out_port_in = rd_entry.port;
               end else if (last_probe) begin
                  rsp_valid_in = 1'b1;
                  status_in = STATUS_UNKNOWN;
                  slot_in = '0;
                  out_id_in = '0;
               end
            end else if (rd_entry.valid && rd_entry.tag_id == id_ff) begin
               if (same_client) begin
                  rsp_valid_in = 1'b1;
                  status_in = STATUS_DUPLICATE;
                  slot_in = 9'(probe_ff);
                  out_id_in = id_ff;
               end else if (draws_ff >= DRAW_LIMIT) begin
                  rsp_valid_in = 1'b1;
                  status_in = STATUS_FULL;
                  slot_in = '0;
                  out_id_in = id_ff;
               end else begin
                  // another client holds the id: draw a fresh one
                  lfsr_in = drawn;
                  id_in = drawn;
                  draws_in = draws_ff + 16'd1;
                  home_start = 1'b1;
                  home_id = drawn;
               end
            end else if (!rd_entry.valid || stale) begin
               ram_we = 1'b1;
               ram_wdata.valid = 1'b1;
               ram_wdata.tag_id = id_ff;
               ram_wdata.real_id = real_ff;
               ram_wdata.ip = ip_ff;
               ram_wdata.port = port_ff;
               ram_wdata.stamp = now_ff;
               rsp_valid_in = 1'b1;
               status_in = STATUS_STORED;
               slot_in = 9'(probe_ff);
               out_id_in = id_ff;
            end else if (last_probe) begin
               rsp_valid_in = 1'b1;
               status_in = STATUS_FULL;
               slot_in = '0;
               out_id_in = id_ff;
            end
            // step to the next slot with wrap-around
            if (state_in == FSM_READ) begin
               probe_in = (probe_ff == LAST_SLOT) ? '0 : probe_ff + 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_CLEAR;
         clr_ff <= '0;
         now_ff <= '0;
         lfsr_ff <= LFSR_SEED;
         timeout_ff <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         now_ff <= now_in;
         lfsr_ff <= lfsr_in;
         timeout_ff <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      id_ff <= id_in;
      real_ff <= real_in;
      ip_ff <= ip_in;
      port_ff <= port_in;
      draws_ff <= draws_in;
      probe_ff <= probe_in;
      count_ff <= count_in;
      status_ff <= status_in;
      slot_ff <= slot_in;
      out_id_ff <= out_id_in;
      out_ip_ff <= out_ip_in;
      out_port_ff <= out_port_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_slot = slot_ff;
   assign rsp_out_id = out_id_ff;
   assign rsp_out_ip = out_ip_ff;
   assign rsp_out_port = out_port_ff;

`ifndef SYNTHESIS
   // table writes come only from the clearing pass or a probe evaluation
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == FSM_CLEAR || state_ff == FSM_EVAL))
      else $error("table write outside clear or evaluate");
   // no result while the table is being cleared
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_CLEAR) |-> !rsp_valid_in)
      else $error("result during clearing pass");
   // a result ends the transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in |=> (state_ff == FSM_IDLE))
      else $error("result without return to idle");
   // an accepted add or answer keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_ADD || req_mode == MODE_ANSWER)) |=> busy)
      else $error("lookup accepted but block not busy");
`endif
endmodule

### tb/tb_dns_query_id_translation_table.sv
// testbench for the dns query id translation table: random and directed adds, answers, ticks
module tb_dns_query_id_translation_table
   import dqt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 10000000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // one transaction into the table
   typedef struct {
      logic [1:0]  mode;
      logic [15:0] qid;
      logic [31:0] ip;
      logic [15:0] port;
   } query_type;

   // one result out of the table
   typedef struct {
      status_type  status;
      logic [8:0]  slot;
      logic [15:0] id;
      logic [31:0] ip;
      logic [15:0] port;
   } answer_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   logic [1:0]   req_mode;
   logic [15:0]  req_query_id;
   logic [31:0]  req_client_ip;
   logic [15:0]  req_client_port;
   logic         rsp_valid;
   logic [2:0]   rsp_status;
   logic [8:0]   rsp_slot;
   logic [15:0]  rsp_out_id;
   logic [31:0]  rsp_out_ip;
   logic [15:0]  rsp_out_port;
   logic         csr_valid;
   logic         csr_ready;
   logic [7:0]   csr_data;

   dns_query_id_translation_table uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_query_id(req_query_id),
      .req_client_ip(req_client_ip), .req_client_port(req_client_port),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_slot(rsp_slot),
      .rsp_out_id(rsp_out_id), .rsp_out_ip(rsp_out_ip), .rsp_out_port(rsp_out_port),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // shadow copy of the pending table
   logic        tbl_valid [DQT_DEPTH];
   logic [15:0] tbl_tag   [DQT_DEPTH];
   logic [15:0] tbl_real  [DQT_DEPTH];
   logic [31:0] tbl_ip    [DQT_DEPTH];
   logic [15:0] tbl_port  [DQT_DEPTH];
   logic [31:0] tbl_stamp [DQT_DEPTH];
   logic [31:0] now_ticks;
   logic [15:0] id_gen;
   logic [7:0]  stale_age;

   query_type  pending_queries[$];
   answer_type expected_answers[$];

   int mismatches = 0;
   int cycles = 0;
   int status_seen [6];
   bit hold_queries;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // fresh nonzero id from the galois lfsr, repeated while the wrap gives zero
   function automatic logic [15:0] draw_fresh_id();
      logic [15:0] v;
      do begin
         id_gen = {1'b0, id_gen[15:1]} ^ (id_gen[0] ? LFSR_MASK : 16'h0000);
         v = id_gen % ID_WRAP;
      end while (v == 16'h0000);
      return v;
   endfunction

   // add: linear probe from the home slot, redraw the id when another client holds it
   function automatic answer_type predict_add(logic [15:0] real_id, logic [31:0] ip,
                                              logic [15:0] port);
      answer_type  r;
      logic [15:0] id;
      int          draws;
      int          p;
      bit          redraw;
      bit          take;
      r = '{STATUS_STORED, 9'd0, 16'd0, 32'd0, 16'd0};
      id = real_id;
      draws = 0;
      forever begin
         redraw = 0;
         for (int n = 0; n < DQT_DEPTH; n++) begin
            p = (id % DQT_DEPTH + n) % DQT_DEPTH;
            take = 0;
            if (!tbl_valid[p]) begin
               take = 1;
            end else if (tbl_tag[p] == id) begin
               if (tbl_ip[p] == ip && tbl_port[p] == port) begin
                  r.status = STATUS_DUPLICATE;
                  r.slot = p[8:0];
                  r.id = id;
                  return r;
               end
               if (draws >= int'(DRAW_LIMIT)) begin
                  r.status = STATUS_FULL;
                  r.id = id;
                  return r;
               end
               id = draw_fresh_id();
               draws++;
               redraw = 1;
               break;
            end else if (now_ticks - tbl_stamp[p] >= {24'd0, stale_age}) begin
               take = 1;
            end
            if (take) begin
               tbl_valid[p] = 1'b1;
               tbl_tag[p] = id;
               tbl_real[p] = real_id;
               tbl_ip[p] = ip;
               tbl_port[p] = port;
               tbl_stamp[p] = now_ticks;
               r.slot = p[8:0];
               r.id = id;
               return r;
            end
         end
         if (!redraw) begin
            r.status = STATUS_FULL;
            r.id = id;
            return r;
         end
      end
   endfunction

   function automatic answer_type predict_query(query_type q);
      answer_type r;
      int         p;
      r = '{STATUS_TICK, 9'd0, 16'd0, 32'd0, 16'd0};
      if (q.mode == MODE_ADD) begin
         return predict_add(q.qid, q.ip, q.port);
      end else if (q.mode == MODE_ANSWER) begin
         r.status = STATUS_UNKNOWN;
         for (int n = 0; n < DQT_DEPTH; n++) begin
            p = (q.qid % DQT_DEPTH + n) % DQT_DEPTH;
            if (tbl_valid[p] && tbl_tag[p] == q.qid) begin
               tbl_valid[p] = 1'b0;
               r = '{STATUS_MATCHED, p[8:0], tbl_real[p], tbl_ip[p], tbl_port[p]};
               break;
            end
         end
      end else if (q.mode == MODE_TICK) begin
         now_ticks = now_ticks + 1;
      end
      return r;
   endfunction

   // driver: launches queued transactions, with a random gap before each
   int        gap;
   query_type cur;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_mode <= '0;
         req_query_id <= '0;
         req_client_ip <= '0;
         req_client_port <= '0;
         gap = $urandom_range(0, 4);
      end else begin
         if (start && !busy) begin
            expected_answers.push_back(predict_query(cur));
         end
         if (!start || !busy) begin
            if (gap > 0) begin
               gap--;
               start <= 1'b0;
            end else if (pending_queries.size() > 0 && !hold_queries) begin
               cur = pending_queries.pop_front();
               req_mode <= cur.mode;
               req_query_id <= cur.qid;
               req_client_ip <= cur.ip;
               req_client_port <= cur.port;
               start <= 1'b1;
               // a stretch is forced back to back with a chance of one in five
               gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 4);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobe is checked against the oldest expectation
   answer_type exp_r;
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: status %0d slot %0d id %h", rsp_status,
                        rsp_slot, rsp_out_id);
            end
         end else begin
            exp_r = expected_answers.pop_front();
            if (rsp_status < 6) begin
               status_seen[rsp_status]++;
            end
            if (rsp_status !== exp_r.status || rsp_slot !== exp_r.slot ||
                rsp_out_id !== exp_r.id || rsp_out_ip !== exp_r.ip ||
                rsp_out_port !== exp_r.port) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected st %0d slot %0d id %h ip %h port %h",
                           exp_r.status, exp_r.slot, exp_r.id, exp_r.ip, exp_r.port);
                  $display("          actual   st %0d slot %0d id %h ip %h port %h",
                           rsp_status, rsp_slot, rsp_out_id, rsp_out_ip, rsp_out_port);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   function automatic query_type mk(logic [1:0] mode, logic [15:0] qid, logic [31:0] ip,
                                    logic [15:0] port);
      query_type q;
      q.mode = mode;
      q.qid = qid;
      q.ip = ip;
      q.port = port;
      return q;
   endfunction

   // wait until every transaction is through and the block has settled
   task automatic wait_idle();
      while (pending_queries.size() > 0 || expected_answers.size() > 0 || start || busy)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // register write, only while idle
   task automatic write_timeout(logic [7:0] v);
      wait_idle();
      csr_data <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      stale_age = v;
   endtask

   // random transactions in short bursts; answers mostly hit ids that are pending
   task automatic random_burst(int n, int tick_pct);
      int          pick;
      int          s;
      logic [15:0] qid;
      logic [31:0] ip;
      logic [15:0] port;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         ip = $urandom;
         port = 16'($urandom);
         qid = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 7) * 512 + 5)
                                           : 16'($urandom);
         if (pick < tick_pct) begin
            pending_queries.push_back(mk(MODE_TICK, 16'($urandom), ip, port));
         end else if (pick < tick_pct + 4) begin
            pending_queries.push_back(mk(MODE_UNUSED, 16'($urandom), ip, port));
         end else if (pick < 55) begin
            // a repeat of a pending client or a clash with its id
            s = $urandom_range(0, DQT_DEPTH - 1);
            if (tbl_valid[s] && $urandom_range(0, 2) == 0) begin
               qid = tbl_real[s];
               if ($urandom_range(0, 1) == 1) begin
                  ip = tbl_ip[s];
                  port = tbl_port[s];
               end
            end
            pending_queries.push_back(mk(MODE_ADD, qid, ip, port));
         end else begin
            for (int t = 0; t < 32; t++) begin
               s = $urandom_range(0, DQT_DEPTH - 1);
               if (tbl_valid[s] && $urandom_range(0, 4) != 0) begin
                  qid = tbl_tag[s];
                  break;
               end
            end
            pending_queries.push_back(mk(MODE_ANSWER, qid, ip, port));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      hold_queries = 0;
      for (int i = 0; i < DQT_DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_tag[i] = '0;
         tbl_real[i] = '0;
         tbl_ip[i] = '0;
         tbl_port[i] = '0;
         tbl_stamp[i] = '0;
      end
      now_ticks = '0;
      id_gen = LFSR_SEED;
      stale_age = TIMEOUT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, wrap-around probing, duplicate, id clash, reclaim, mode three
      pending_queries.push_back(mk(MODE_TICK, 16'h0000, 32'h0, 16'h0));
      pending_queries.push_back(mk(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
      pending_queries.push_back(mk(MODE_ADD, 16'h0000, 32'h0, 16'h0));
      pending_queries.push_back(mk(MODE_ADD, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
      pending_queries.push_back(mk(MODE_ADD, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
      pending_queries.push_back(mk(MODE_ADD, 16'hFFFF, 32'h0A00_0001, 16'h0035));
      pending_queries.push_back(mk(MODE_ADD, 16'h01FF, 32'h5555_5555, 16'hAAAA));
      pending_queries.push_back(mk(MODE_ADD, 16'h03FF, 32'hAAAA_AAAA, 16'h5555));
      pending_queries.push_back(mk(MODE_ANSWER, 16'h1234, 32'h0, 16'h0));
      pending_queries.push_back(mk(MODE_ANSWER, 16'h03FF, 32'h0, 16'h0));
      pending_queries.push_back(mk(MODE_ANSWER, 16'hFFFF, 32'h0, 16'h0));
      pending_queries.push_back(mk(MODE_ANSWER, 16'h0000, 32'h0, 16'h0));
      for (int i = 0; i < 3; i++)
         pending_queries.push_back(mk(MODE_TICK, 16'h0, 32'h0, 16'h0));
      // an add takes the home slot that an answer has freed
      pending_queries.push_back(mk(MODE_ADD, 16'h05FF, 32'h1234_5678, 16'h9ABC));
      pending_queries.push_back(mk(MODE_ANSWER, 16'h01FF, 32'h0, 16'h0));
      pending_queries.push_back(mk(MODE_ANSWER, 16'h05FF, 32'h0, 16'h0));

      // timeout zero: every entry is reclaimable
      write_timeout(8'd0);
      for (int b = 0; b < 6; b++) begin
         random_burst(10, 10);
         wait_idle();
      end

      // maximum timeout and no ticks: fill the table until adds are dropped as full
      write_timeout(8'd255);
      for (int b = 0; b < 26; b++) begin
         for (int i = 0; i < 20; i++)
            pending_queries.push_back(mk(MODE_ADD, 16'($urandom), $urandom, 16'($urandom)));
      end
      for (int i = 0; i < 4; i++)
         pending_queries.push_back(mk(MODE_ANSWER, 16'($urandom), 32'h0, 16'h0));
      // halfway through, the sender holds off until the table has answered everything
      while (pending_queries.size() > 260) @(posedge clock);
      hold_queries = 1;
      while (expected_answers.size() > 0 || start || busy) @(posedge clock);
      repeat (5) @(posedge clock);
      hold_queries = 0;
      wait_idle();

      // free some slots, then drain the full table under timeout zero
      random_burst(10, 0);
      wait_idle();
      write_timeout(8'd0);
      for (int b = 0; b < 4; b++) begin
         random_burst(10, 5);
         wait_idle();
      end

      // random timeouts with plenty of ticks so entries age
      for (int k = 0; k < 5; k++) begin
         write_timeout(8'($urandom_range(1, 6)));
         for (int b = 0; b < 6; b++) begin
            random_burst(10, 30);
            wait_idle();
         end
      end
      write_timeout(TIMEOUT_RESET);
      random_burst(20, 20);
      wait_idle();

      $display("covered: %0d stored, %0d duplicate, %0d full, %0d matched, %0d unknown,",
               status_seen[STATUS_STORED], status_seen[STATUS_DUPLICATE],
               status_seen[STATUS_FULL], status_seen[STATUS_MATCHED],
               status_seen[STATUS_UNKNOWN]);
      $display("%0d tick results over timeouts 0, 255, 3 and random; %0d mismatches",
               status_seen[STATUS_TICK], mismatches);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
